// ----- design/swsal_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsal_pkg
// Shared constants and types for the shortest-window-sum block.
// ----------------------------------------------------------------------------
package swsal_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VALUE_W   = 16;
    localparam int SUM_W     = 32;
    localparam int LEN_W     = 11;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_POP   = 4'b0100,
        ST_EMIT  = 4'b1000
    } swsal_state_t;

    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] items_seen;
        logic [CNT_W-1:0] window_start;
    } swsal_status_t;

endpackage

// ----- design/swsal_value_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsal_value_mem
// Value store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swsal_value_mem
    import swsal_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [VALUE_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [VALUE_W-1:0] rd_data
);

    logic [VALUE_W-1:0] mem [MAX_ITEMS];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/swsal_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsal_core
// Sequencer and window datapath: one shared add/subtract unit and the
// window compares, stepping the left edge one entry per pop.
// ----------------------------------------------------------------------------
module swsal_core
    import swsal_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [SUM_W-1:0]   target,
    input  logic               start,
    input  logic [VALUE_W-1:0] value,
    input  logic               last,
    output logic               res_valid,
    input  logic               res_take,
    output logic [LEN_W-1:0]   res_length,
    output logic               res_overflow,
    output swsal_status_t      status
);

    swsal_state_t       state_reg, state_next;
    logic [CNT_W-1:0]   ws_reg, ws_next;
    logic [CNT_W-1:0]   seen_reg, seen_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   best_reg, best_next;
    logic               ovf_reg, ovf_next;
    logic [ADDR_W-1:0]  right_reg, right_next;
    logic               last_reg, last_next;

    logic               space;
    logic               hit;
    logic [CNT_W-1:0]   len;
    logic [SUM_W-1:0]   operand;
    logic [SUM_W-1:0]   alu_out;
    logic               mem_wr_en;
    logic               mem_rd_en;
    logic [VALUE_W-1:0] mem_rd_data;

    swsal_value_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (seen_reg[ADDR_W-1:0]),
        .wr_data (value),
        .rd_en   (mem_rd_en),
        .rd_addr (ws_reg[ADDR_W-1:0]),
        .rd_data (mem_rd_data)
    );

    assign space = seen_reg < CNT_W'(MAX_ITEMS);
    assign hit   = (CNT_W'(right_reg) >= ws_reg) && (sum_reg >= target);
    assign len   = CNT_W'(right_reg) - ws_reg + CNT_W'(1);

    // shared unit: add the new value on accept, subtract the popped value
    assign operand = (state_reg == ST_POP) ? SUM_W'(mem_rd_data) : SUM_W'(value);
    assign alu_out = (state_reg == ST_POP) ? (sum_reg - operand) : (sum_reg + operand);

    always_comb
    begin
        state_next = state_reg;
        ws_next    = ws_reg;
        seen_next  = seen_reg;
        sum_next   = sum_reg;
        best_next  = best_reg;
        ovf_next   = ovf_reg;
        right_next = right_reg;
        last_next  = last_reg;
        mem_wr_en  = 1'b0;
        mem_rd_en  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    last_next = last;
                    if (space)
                    begin
                        mem_wr_en  = 1'b1;
                        sum_next   = alu_out;
                        right_next = seen_reg[ADDR_W-1:0];
                        seen_next  = seen_reg + CNT_W'(1);
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        // dropped item: window is not evaluated again
                        ovf_next   = 1'b1;
                        state_next = last ? ST_EMIT : ST_IDLE;
                    end
                end
            end
            ST_CHECK:
            begin
                if (hit)
                begin
                    if ((best_reg == '0) || (len < best_reg))
                    begin
                        best_next = len;
                    end
                    mem_rd_en  = 1'b1;
                    state_next = ST_POP;
                end
                else if (last_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP:
            begin
                sum_next   = alu_out;
                ws_next    = ws_reg + CNT_W'(1);
                state_next = ST_CHECK;
            end
            ST_EMIT:
            begin
                if (res_take)
                begin
                    ws_next    = '0;
                    seen_next  = '0;
                    sum_next   = '0;
                    best_next  = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ws_reg    <= '0;
            seen_reg  <= '0;
            sum_reg   <= '0;
            best_reg  <= '0;
            ovf_reg   <= 1'b0;
            right_reg <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ws_reg    <= ws_next;
            seen_reg  <= seen_next;
            sum_reg   <= sum_next;
            best_reg  <= best_next;
            ovf_reg   <= ovf_next;
            right_reg <= right_next;
            last_reg  <= last_next;
        end
    end

    assign res_valid           = (state_reg == ST_EMIT);
    assign res_length          = LEN_W'(best_reg);
    assign res_overflow        = ovf_reg;
    assign status.idle         = (state_reg == ST_IDLE);
    assign status.items_seen   = seen_reg;
    assign status.window_start = ws_reg;

endmodule

// ----- design/shortest_window_sum_at_least.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_window_sum_at_least
// Shortest window of a value sequence whose sum reaches a target.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one value per item, last marks the end
//   of a sequence. Output channel (out_valid/out_ready): one item per
//   sequence, the shortest qualifying length (0 if none) and an overflow flag
//   set when more than MAX_ITEMS values arrived and the rest were dropped.
//   cfg_we/cfg_wdata write target_sum; write it only while the block is idle.
// Sequencing:
//   Each item has an accept step and a compare step, then per entry popped
//   off the left edge a value-store read plus the subtract on the shared
//   adder, and another compare. Pops total at most one per stored value.
//   The block takes no new item until it is done with the current one.
//   A dropped item past MAX_ITEMS has only its accept step.
//   A last item then enters the emit step to hand its result to the output register.
// Reset: sequence state clears, target_sum returns to 1, output goes idle.
// Stall: a result waits in the output register; the next items are still
//   taken, and only a following last item waits until out_ready frees it.
// ----------------------------------------------------------------------------
module shortest_window_sum_at_least
    import swsal_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SUM_W-1:0]   cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] value,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [LEN_W-1:0]   shortest_length,
    output logic               overflow
);

    logic [SUM_W-1:0] target_reg;
    logic             out_valid_reg;
    logic [LEN_W-1:0] length_reg;
    logic             overflow_reg;

    logic             res_valid;
    logic             res_take;
    logic [LEN_W-1:0] res_length;
    logic             res_overflow;
    swsal_status_t    status;

    assign in_ready = status.idle;
    assign res_take = !out_valid_reg || out_ready;

    swsal_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .target       (target_reg),
        .start        (in_valid && in_ready),
        .value        (value),
        .last         (last),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res_length   (res_length),
        .res_overflow (res_overflow),
        .status       (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= SUM_W'(1);
        end
        else if (cfg_we)
        begin
            target_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            length_reg   <= res_length;
            overflow_reg <= res_overflow;
        end
    end

    assign out_valid       = out_valid_reg;
    assign shortest_length = length_reg;
    assign overflow        = overflow_reg;

    // a stored item always passes through the compare step before the block is ready again
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (status.items_seen < CNT_W'(MAX_ITEMS))) |=> !in_ready)
        else $error("block ready right after taking an item");

    // left edge never passes the right edge of the stored values
    assert property (@(posedge clk) disable iff (!rst_n)
        status.window_start <= status.items_seen)
        else $error("window start beyond stored items");

    // a reported length never exceeds the buffer depth
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (CNT_W'(shortest_length) <= CNT_W'(MAX_ITEMS)))
        else $error("result length beyond buffer depth");

    // a new result only loads when the core is handing one over
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !res_valid) |=> !out_valid)
        else $error("result appeared without a finished sequence");

endmodule

// ----- tb/tb_shortest_window_sum_at_least.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shortest_window_sum_at_least
// Self-checking bench for the shortest-window-sum block. Directed sequences
// cover the target extremes, window shrinking and buffer overflow. Random
// sequences then run under several targets with bursty input gaps and output
// stalls. Every result is compared against an in-bench window predictor.
// ----------------------------------------------------------------------------
module tb_shortest_window_sum_at_least;
    import swsal_pkg::*;

    localparam int CLK_HALF           = 4;
    localparam int DRAIN_CYCLES       = 2 * MAX_ITEMS + 16;
    localparam int CYCLE_LIMIT        = 500000;
    localparam int RANDOM_ITEMS       = 420;
    localparam int ITEMS_PER_TARGET   = 70;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             ovf;
    } window_result_t;

    typedef enum int {
        FILL_FULL,
        FILL_SMALL,
        FILL_SPARSE,
        FILL_EXTREME
    } fill_mode_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [SUM_W-1:0]   cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               out_valid;
    logic               out_ready;
    logic [LEN_W-1:0]   shortest_length;
    logic               overflow;

    // predictor state
    logic [VALUE_W-1:0] stored_values [MAX_ITEMS];
    int unsigned        win_left;
    int unsigned        fill_count;
    int unsigned        best_len;
    logic [SUM_W-1:0]   window_total;
    logic [SUM_W-1:0]   target_model;
    logic               overflow_model;
    window_result_t     pending_results [$];

    int error_count  = 0;
    int cycle_count  = 0;
    int items_sent   = 0;
    bit send_gaps;
    bit stall_enable;

    shortest_window_sum_at_least dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .value           (value),
        .last            (last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .shortest_length (shortest_length),
        .overflow        (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Window predictor
    // ------------------------------------------------------------------
    function void clear_window();
        win_left       = 0;
        fill_count     = 0;
        best_len       = 0;
        window_total   = '0;
        overflow_model = 1'b0;
    endfunction

    function void predict_item(input logic [VALUE_W-1:0] v, input logic l);
        int unsigned    right;
        int unsigned    len;
        window_result_t res;
        if (fill_count < MAX_ITEMS)
        begin
            right = fill_count;
            stored_values[right] = v;
            fill_count = right + 1;
            window_total = window_total + SUM_W'(v);
            // shrink from the left; an empty window also stops it (target 0)
            while (win_left <= right && window_total >= target_model)
            begin
                len = right - win_left + 1;
                if (best_len == 0 || len < best_len)
                    best_len = len;
                window_total = window_total - SUM_W'(stored_values[win_left]);
                win_left++;
            end
        end
        else
            overflow_model = 1'b1;
        if (l)
        begin
            res.length = LEN_W'(best_len);
            res.ovf    = overflow_model;
            pending_results.push_back(res);
            clear_window();
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d, at %0t", what, got, want, $time);
        error_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        window_result_t want_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, length", int'(shortest_length), -1);
            else
            begin
                want_res = pending_results.pop_front();
                if (shortest_length !== want_res.length)
                    report_mismatch("shortest_length", int'(shortest_length),
                                    int'(want_res.length));
                if (overflow !== want_res.ovf)
                    report_mismatch("overflow", int'(overflow), int'(want_res.ovf));
            end
        end
    end

    // output stalls in bursts of random length while stall_enable is set
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_enable && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task send_item(input logic [VALUE_W-1:0] v, input logic l);
        int gap;
        gap = (send_gaps && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_item(v, l);
        items_sent++;
    endtask

    task wait_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task settle();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task write_target(input logic [SUM_W-1:0] t);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= t;
        @(negedge clk);
        cfg_we    <= 1'b0;
        target_model = t;
    endtask

    function automatic logic [VALUE_W-1:0] rand_value(input fill_mode_t mode);
        case (mode)
            FILL_SMALL:   return VALUE_W'($urandom_range(0, 255));
            FILL_SPARSE:  return ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom) : '0;
            FILL_EXTREME: return ($urandom_range(0, 1) == 1) ? '1 : '0;
            default:      return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic [SUM_W-1:0] pick_target(input int phase);
        case (phase % 4)
            0:       return SUM_W'($urandom_range(1, 16));
            1:       return SUM_W'($urandom_range(1000, 300000));
            2:       return SUM_W'(65535 * $urandom_range(1, 12));
            default: return SUM_W'($urandom_range(100, 2000000));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task test_default_target();
        // target stays at its reset value of 1
        send_item('0, 1'b1);
        send_item('1, 1'b1);
        send_item('0, 1'b0);
        send_item('0, 1'b0);
        send_item(16'd1, 1'b1);
        send_item(16'd3, 1'b1);
    endtask

    task test_window_shrink();
        write_target(32'd100);
        send_item(16'd60, 1'b0);
        send_item(16'd30, 1'b0);
        send_item(16'd20, 1'b0);
        send_item(16'd50, 1'b0);
        send_item(16'd50, 1'b1);
        send_item(16'd99, 1'b0);
        send_item(16'd1, 1'b1);
        send_item(16'd100, 1'b1);
    endtask

    task test_target_extremes();
        // zero target: every single element qualifies
        write_target('0);
        send_item('0, 1'b0);
        send_item('0, 1'b0);
        send_item(16'd7, 1'b1);
        // unreachable target
        write_target('1);
        send_item('1, 1'b0);
        send_item('1, 1'b0);
        send_item('1, 1'b1);
    endtask

    task test_buffer_overflow();
        int k;
        // only the full buffer reaches the target: length is MAX_ITEMS
        write_target(SUM_W'(MAX_ITEMS * 65535));
        for (k = 1; k <= MAX_ITEMS + 3; k++)
            send_item('1, k == MAX_ITEMS + 3);
        // next sequence must start clean
        send_item(16'h5a5a, 1'b1);
    endtask

    task test_random_sequences();
        int         start_items;
        int         phase;
        int         seq_len;
        int         k;
        bit         quiet_tail;
        fill_mode_t mode;
        start_items   = items_sent;
        phase         = 0;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            if (items_sent - start_items >= phase * ITEMS_PER_TARGET)
            begin
                quiet_tail   = (items_sent - start_items >= RANDOM_ITEMS - ITEMS_PER_TARGET);
                write_target(pick_target(phase));
                send_gaps    = !quiet_tail;
                stall_enable = !quiet_tail;
                phase++;
            end
            if ($urandom_range(0, 19) == 0)
                seq_len = $urandom_range(40, 120);
            else
                seq_len = $urandom_range(1, 20);
            mode = fill_mode_t'($urandom_range(0, 3));
            for (k = 1; k <= seq_len; k++)
                send_item(rand_value(mode), k == seq_len);
            // now and then hold the input until the output side catches up
            if ($urandom_range(0, 11) == 0)
                wait_results();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        value        = '0;
        last         = 1'b0;
        send_gaps    = 1'b1;
        stall_enable = 1'b1;
        clear_window();
        target_model = SUM_W'(1);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_target();
        test_window_shrink();
        test_target_extremes();
        test_buffer_overflow();
        test_random_sequences();

        settle();
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/swsal_pkg.sv
design/swsal_value_mem.sv
design/swsal_core.sv
design/shortest_window_sum_at_least.sv
tb/tb_shortest_window_sum_at_least.sv
